/* rtl/dltq_pkg.sv */
// ----------------------------------------------------------------------------
// dltq_pkg - shared types and codes of the delta list timer queue
// Command and response structs, operation and status codes, cell controls.
// ----------------------------------------------------------------------------
package dltq_pkg;

	// operation codes carried in cmd_t.mode
	localparam logic [2:0] MODE_CREATE = 3'd0;
	localparam logic [2:0] MODE_START  = 3'd1;
	localparam logic [2:0] MODE_STOP   = 3'd2;
	localparam logic [2:0] MODE_DELETE = 3'd3;
	localparam logic [2:0] MODE_TICK   = 3'd4;

	// status codes carried in rsp_t.status
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_PARAM   = 2'd1;
	localparam logic [1:0] STAT_RESOURCE = 2'd2;

	// most expiry reports one tick may give
	localparam int MAX_RESULTS = 16;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  timer_index;
		logic [31:0] ticks;
		logic        periodic;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic       running;
		logic       expired_valid;
		logic [3:0] expired_index;
		logic       last;
	} rsp_t;

	// list edit broadcast to every cell
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_REMOVE,
		CELL_POP,
		CELL_INSERT,
		CELL_DEC
	} cell_op_e;

	typedef struct packed {
		cell_op_e    op;
		logic [31:0] delta;
	} cell_ctl_t;

endpackage

/* rtl/dltq_ram.sv */
// ----------------------------------------------------------------------------
// dltq_ram - generic single write port RAM with registered read
// One write and one read address per cycle.
// ----------------------------------------------------------------------------
module dltq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/dltq_cell.sv */
// ----------------------------------------------------------------------------
// dltq_cell - one position of the delta-sorted timer list
// Holds a slot number and its delay relative to the position before it.
// ----------------------------------------------------------------------------
module dltq_cell import dltq_pkg::*; #(
	parameter int IDX = 0,
	parameter int SW  = 4,
	parameter int PW  = 4
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [PW-1:0] pos,
	input  logic [SW-1:0] ins_slot,
	input  logic [SW-1:0] left_slot,
	input  logic [31:0]   left_delta,
	input  logic [SW-1:0] right_slot,
	input  logic [31:0]   right_delta,
	output logic [SW-1:0] slot,
	output logic [31:0]   delta
);

	localparam int PREV = (IDX > 0) ? IDX - 1 : 0;

	logic [SW-1:0] slot_q;
	logic [31:0]   delta_q;
	logic          at;
	logic          after;
	logic          next_of;

	assign at      = (pos == PW'(IDX));
	assign after   = (PW'(IDX) > pos);
	assign next_of = (IDX > 0) && (PW'(PREV) == pos);

	// apply the broadcast list edit at this position
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_HOLD: begin
			end
			CELL_REMOVE: begin
				if (at) begin
					slot_q  <= right_slot;
					delta_q <= right_delta + delta_q;
				end else if (after) begin
					slot_q  <= right_slot;
					delta_q <= right_delta;
				end
			end
			CELL_POP: begin
				slot_q  <= right_slot;
				delta_q <= right_delta;
			end
			CELL_INSERT: begin
				if (at) begin
					slot_q  <= ins_slot;
					delta_q <= ctl.delta;
				end else if (next_of) begin
					slot_q  <= left_slot;
					delta_q <= left_delta - ctl.delta;
				end else if (after) begin
					slot_q  <= left_slot;
					delta_q <= left_delta;
				end
			end
			CELL_DEC: begin
				if (IDX == 0) begin
					delta_q <= delta_q - 32'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign slot  = slot_q;
	assign delta = delta_q;

endmodule

/* rtl/delta_list_timer_queue_top.sv */
// ----------------------------------------------------------------------------
// delta_list_timer_queue_top - bank of timers in a delta-sorted list
// Create, start, stop, delete timers and advance time; report expiries.
//
//   channel | valid     | stall     | payload | moves
//   --------+-----------+-----------+---------+-------------------------------
//   command | cmd_valid | cmd_stall | cmd     | one operation per transfer
//   result  | rsp_valid | rsp_stall | rsp     | one result per transfer
//
// One command at a time; cmd_stall is high from the command transfer until its
// last result is loaded. Errors and create/delete of a stopped slot go straight
// to the result; stop and create or delete of a running timer first remove it
// from the list; start walks past up to NUM_TIMERS - 1 list positions to its
// place (a restart removes it first). A tick decrements the head, then pops and
// reports each expired head; a periodic one is walked back in with its reload.
// Reset empties the list and clears all flags at once.
// A stalled result holds; the queue waits until it is taken.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_top import dltq_pkg::*; #(
	parameter int NUM_TIMERS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int SW = $clog2(NUM_TIMERS);
	localparam int PW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_FIND, ST_REMOVE, ST_WALK, ST_RESP,
		ST_TICK_DEC, ST_TICK_CHK, ST_TICK_POP, ST_TICK_RLD, ST_TICK_EMIT
	} state_e;

	state_e                state_q;
	cmd_t                  cmd_q;
	logic [1:0]            stat_q;
	logic [SW-1:0]         t_q;
	logic [PW-1:0]         pos_q;
	logic [PW-1:0]         walk_q;
	logic [31:0]           rem_q;
	logic [CW-1:0]         count_q;
	logic [4:0]            nres_q;
	logic [NUM_TIMERS-1:0] run_q;
	logic [NUM_TIMERS-1:0] valid_q;
	logic [NUM_TIMERS-1:0] per_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic [SW-1:0] cell_slot  [NUM_TIMERS];
	logic [31:0]   cell_delta [NUM_TIMERS];
	cell_ctl_t     ctl;
	logic [PW-1:0] ctl_pos;
	logic [PW-1:0] found_pos;
	logic [31:0]   walk_delta;
	logic [31:0]   reload_rd;
	logic          ram_we;

	logic          slot_ok;
	logic [SW-1:0] sidx;
	logic          is_valid;
	logic          is_run;
	logic          rsp_free;
	logic          rsp_load;
	logic          more;
	logic          walk_step;

	// decode the held command
	assign slot_ok  = (32'(cmd_q.timer_index) < NUM_TIMERS);
	assign sidx     = SW'(cmd_q.timer_index);
	assign is_valid = slot_ok && valid_q[sidx];
	assign is_run   = slot_ok && run_q[sidx];
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign rsp_load = ((state_q == ST_RESP) || (state_q == ST_TICK_EMIT)) && rsp_free;
	assign more     = (count_q != '0) && (cell_delta[0] == 32'd0)
	                  && (nres_q < 5'(MAX_RESULTS - 1));
	assign walk_delta = cell_delta[walk_q];
	assign walk_step  = (CW'(walk_q) < count_q) && (walk_delta <= rem_q);

	// locate the addressed slot in the list
	always_comb begin
		found_pos = '0;
		for (int k = 0; k < NUM_TIMERS; k++) begin
			if ((CW'(k) < count_q) && (cell_slot[k] == t_q)) begin
				found_pos = PW'(k);
			end
		end
	end

	// drive the list edit for this cycle
	always_comb begin
		ctl.op    = CELL_HOLD;
		ctl.delta = rem_q;
		ctl_pos   = '0;
		unique case (state_q)
			ST_REMOVE: begin
				ctl.op  = CELL_REMOVE;
				ctl_pos = pos_q;
			end
			ST_WALK: begin
				if (!walk_step) begin
					ctl.op  = CELL_INSERT;
					ctl_pos = walk_q;
				end
			end
			ST_TICK_DEC: ctl.op = CELL_DEC;
			ST_TICK_POP: ctl.op = CELL_POP;
			default: begin
			end
		endcase
	end

	// row of list cells
	for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
		logic [SW-1:0] l_slot;
		logic [31:0]   l_delta;
		logic [SW-1:0] r_slot;
		logic [31:0]   r_delta;
		if (k == 0) begin : g_first
			assign l_slot  = '0;
			assign l_delta = '0;
		end else begin : g_mid
			assign l_slot  = cell_slot[k-1];
			assign l_delta = cell_delta[k-1];
		end
		if (k == NUM_TIMERS - 1) begin : g_end
			assign r_slot  = '0;
			assign r_delta = '0;
		end else begin : g_inner
			assign r_slot  = cell_slot[k+1];
			assign r_delta = cell_delta[k+1];
		end
		dltq_cell #(.IDX(k), .SW(SW), .PW(PW)) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.pos         (ctl_pos),
			.ins_slot    (t_q),
			.left_slot   (l_slot),
			.left_delta  (l_delta),
			.right_slot  (r_slot),
			.right_delta (r_delta),
			.slot        (cell_slot[k]),
			.delta       (cell_delta[k])
		);
	end

	// reload values, written on a fresh start, read for periodic reinsertion
	assign ram_we = (state_q == ST_DECODE) && (cmd_q.mode == MODE_START) && is_valid
	                && (cmd_q.ticks != 32'd0) && !is_run;

	dltq_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_reload (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sidx),
		.wdata (cmd_q.ticks),
		.raddr (cell_slot[0]),
		.rdata (reload_rd)
	);

	// sequence one command and its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			run_q       <= '0;
			valid_q     <= '0;
			per_q       <= '0;
			rsp_valid_q <= 1'b0;
			nres_q      <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					t_q    <= sidx;
					stat_q <= STAT_OK;
					walk_q <= '0;
					rem_q  <= cmd_q.ticks;
					unique case (cmd_q.mode)
						MODE_CREATE: begin
							if (!slot_ok) begin
								stat_q  <= STAT_PARAM;
								state_q <= ST_RESP;
							end else begin
								run_q[sidx]   <= 1'b0;
								valid_q[sidx] <= 1'b1;
								per_q[sidx]   <= cmd_q.periodic;
								state_q       <= is_run ? ST_FIND : ST_RESP;
							end
						end
						MODE_START: begin
							if (!is_valid || cmd_q.ticks == 32'd0) begin
								stat_q  <= STAT_PARAM;
								state_q <= ST_RESP;
							end else if (is_run) begin
								state_q <= ST_FIND;
							end else begin
								run_q[sidx] <= 1'b1;
								state_q     <= ST_WALK;
							end
						end
						MODE_STOP: begin
							if (!is_valid) begin
								stat_q  <= STAT_PARAM;
								state_q <= ST_RESP;
							end else if (!is_run) begin
								stat_q  <= STAT_RESOURCE;
								state_q <= ST_RESP;
							end else begin
								run_q[sidx] <= 1'b0;
								state_q     <= ST_FIND;
							end
						end
						MODE_DELETE: begin
							if (!is_valid) begin
								stat_q  <= STAT_PARAM;
								state_q <= ST_RESP;
							end else begin
								run_q[sidx]   <= 1'b0;
								valid_q[sidx] <= 1'b0;
								per_q[sidx]   <= 1'b0;
								state_q       <= is_run ? ST_FIND : ST_RESP;
							end
						end
						MODE_TICK: begin
							nres_q  <= '0;
							state_q <= (count_q == '0) ? ST_RESP : ST_TICK_DEC;
						end
						default: begin
							stat_q  <= STAT_PARAM;
							state_q <= ST_RESP;
						end
					endcase
				end
				ST_FIND: begin
					pos_q   <= found_pos;
					state_q <= ST_REMOVE;
				end
				ST_REMOVE: begin
					count_q <= count_q - CW'(1);
					state_q <= (cmd_q.mode == MODE_START) ? ST_WALK : ST_RESP;
				end
				ST_WALK: begin
					if (walk_step) begin
						rem_q  <= rem_q - walk_delta;
						walk_q <= walk_q + PW'(1);
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= (cmd_q.mode == MODE_TICK) ? ST_TICK_EMIT : ST_RESP;
					end
				end
				ST_RESP: begin
					if (rsp_free) begin
						rsp_q.status        <= stat_q;
						rsp_q.running       <= (cmd_q.mode != MODE_TICK) && is_run;
						rsp_q.expired_valid <= 1'b0;
						rsp_q.expired_index <= '0;
						rsp_q.last          <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				ST_TICK_DEC: begin
					state_q <= ST_TICK_CHK;
				end
				ST_TICK_CHK: begin
					state_q <= (cell_delta[0] == 32'd0) ? ST_TICK_POP : ST_RESP;
				end
				ST_TICK_POP: begin
					t_q     <= cell_slot[0];
					walk_q  <= '0;
					count_q <= count_q - CW'(1);
					if (per_q[cell_slot[0]]) begin
						state_q <= ST_TICK_RLD;
					end else begin
						run_q[cell_slot[0]] <= 1'b0;
						state_q             <= ST_TICK_EMIT;
					end
				end
				ST_TICK_RLD: begin
					rem_q   <= reload_rd;
					state_q <= ST_WALK;
				end
				ST_TICK_EMIT: begin
					if (rsp_free) begin
						rsp_q.status        <= STAT_OK;
						rsp_q.running       <= run_q[t_q];
						rsp_q.expired_valid <= 1'b1;
						rsp_q.expired_index <= 4'(t_q);
						rsp_q.last          <= !more;
						nres_q              <= nres_q + 5'd1;
						state_q             <= more ? ST_TICK_POP : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
